@@ sv/dvru_pkg.sv @@
package dvru_pkg;

    // action codes carried on the input tuser
    localparam logic [1:0] ACT_LOAD     = 2'd0;
    localparam logic [1:0] ACT_NEIGH    = 2'd1;
    localparam logic [1:0] ACT_ANNOUNCE = 2'd2;

    // fixed field widths
    localparam int unsigned IDX_W  = 3;
    localparam int unsigned GATE_W = 5;
    localparam int unsigned ACT_W  = 2;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_RD_SRC  = 5'b00010,
        ST_RD_DST  = 5'b00100,
        ST_EMIT_RD = 5'b01000,
        ST_EMIT_WR = 5'b10000
    } t_state;

    // write request into the routing table
    typedef struct packed {
        logic                 en;
        logic [GATE_W-1:0]    hop;
    } t_wr_ctl;

endpackage

@@ sv/dvru_table.sv @@
module dvru_table #(
    parameter int NODES     = 8,
    parameter int COST_BITS = 16,
    localparam int IW       = $clog2(NODES)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dvru_pkg::t_wr_ctl           i_wr,
    input  logic [IW-1:0]               i_wr_addr,
    input  logic [COST_BITS-1:0]        i_wr_cost,
    input  logic [IW-1:0]               i_rd_addr,
    output logic [COST_BITS-1:0]        o_rd_cost,
    output logic [dvru_pkg::GATE_W-1:0] o_rd_hop
);

    logic [COST_BITS-1:0]        r_cost_mem [NODES];
    logic [dvru_pkg::GATE_W-1:0] r_hop_mem  [NODES];
    logic [NODES-1:0]            r_vld;
    logic [COST_BITS-1:0]        r_rd_cost;
    logic [dvru_pkg::GATE_W-1:0] r_rd_hop;
    logic                        r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_cost_mem[i_wr_addr] <= i_wr_cost;
            r_hop_mem[i_wr_addr]  <= i_wr.hop;
        end
        r_rd_cost <= r_cost_mem[i_rd_addr];
        r_rd_hop  <= r_hop_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_rd_addr];
        end
    end

    // an entry never written reads as unreachable with no gate
    assign o_rd_cost = r_rd_vld ? r_rd_cost : '1;
    assign o_rd_hop  = r_rd_vld ? r_rd_hop  : '1;

endmodule

@@ sv/distance_vector_route_update_top.sv @@
// Distance-vector routing table update.
// Input stream (s_axis): tuser holds the action (load entry, neighbour vector
// entry, announce); tdata holds source, dest, cost and gate; tlast marks the
// final entry of a neighbour vector. An item is taken on tvalid & tready.
// Output stream (m_axis): one transfer per destination 0..NODES-1 in order,
// tdata holds dest and cost (all ones = unreachable), tlast on the final one.
// Sequencing: a load is handled without leaving idle, and so is a neighbour
// entry whose advertised cost is unreachable. Any other neighbour entry goes
// through RD_SRC and RD_DST: read the link cost to the source, read the
// current cost to dest, then one shared saturating add and compare with
// write-back, all over the single read port of the table. Emitting a vector
// (announce, or last entry after a change) walks the table, EMIT_RD then
// EMIT_WR per result; a stalled result is held in the output register and
// the walk waits. s_axis_tready is high only while the sequencer is idle; a
// final result may still wait for its transfer while the next item is taken.
// Reset: synchronous, active low. All table entries read unreachable with no
// gate, the change flag clears and no output is pending; no clearing pass.
module distance_vector_route_update_top #(
    parameter int NODES     = 8,
    parameter int COST_BITS = 16,
    localparam int IN_W     = ((11 + COST_BITS + 7) / 8) * 8,
    localparam int OUT_W    = ((3 + COST_BITS + 7) / 8) * 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [IN_W-1:0]             s_axis_tdata,  // source, dest, cost, gate
    input  logic [dvru_pkg::ACT_W-1:0]  s_axis_tuser,  // action
    input  logic                        s_axis_tlast,  // last
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [OUT_W-1:0]            m_axis_tdata,  // dest_out, cost_out
    output logic                        m_axis_tlast   // last_out
);

    localparam int IW = $clog2(NODES);
    localparam int XW = IW + dvru_pkg::IDX_W;
    localparam int CB = COST_BITS;
    localparam int GW = dvru_pkg::GATE_W;

    dvru_pkg::t_state r_state, n_state;

    logic [2:0]      in_src, in_dst;
    logic [CB-1:0]   in_cost;
    logic [GW-1:0]   in_gate;
    logic [XW-1:0]   src_x, dst_x;
    logic            src_ok, dst_ok;
    logic            accept;

    logic [IW-1:0]   r_dst_idx, n_dst_idx;
    logic [CB-1:0]   r_cost, n_cost;
    logic            r_last, n_last;
    logic [CB-1:0]   r_link, n_link;
    logic [GW-1:0]   r_link_hop, n_link_hop;
    logic [IW-1:0]   r_k, n_k;
    logic            r_changed, n_changed;

    logic            r_out_valid, n_out_valid;
    logic [2:0]      r_out_dest, n_out_dest;
    logic [CB-1:0]   r_out_cost, n_out_cost;
    logic            r_out_last, n_out_last;

    dvru_pkg::t_wr_ctl wr;
    logic [IW-1:0]   wr_addr;
    logic [CB-1:0]   wr_cost;
    logic [IW-1:0]   rd_addr;
    logic [CB-1:0]   rd_cost;
    logic [GW-1:0]   rd_hop;

    logic [CB-1:0]   sum, cand;
    logic            better;
    logic [XW-1:0]   k_x;

    assign in_src  = s_axis_tdata[2:0];
    assign in_dst  = s_axis_tdata[5:3];
    assign in_cost = s_axis_tdata[6 +: CB];
    assign in_gate = s_axis_tdata[6 + CB +: GW];

    assign src_x  = XW'(in_src);
    assign dst_x  = XW'(in_dst);
    assign src_ok = src_x < XW'(NODES);
    assign dst_ok = dst_x < XW'(NODES);
    assign k_x    = XW'(r_k);

    assign s_axis_tready = (r_state == dvru_pkg::ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // shared saturating add and compare; r_cost >= 0, r_link may be unreachable
    assign sum    = r_cost + r_link;
    assign cand   = sum[CB-1] ? {1'b0, {(CB-1){1'b1}}} : sum;
    assign better = rd_cost[CB-1] || (rd_cost > cand);

    dvru_table #(
        .NODES     (NODES),
        .COST_BITS (COST_BITS)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (wr),
        .i_wr_addr (wr_addr),
        .i_wr_cost (wr_cost),
        .i_rd_addr (rd_addr),
        .o_rd_cost (rd_cost),
        .o_rd_hop  (rd_hop)
    );

    always_comb begin
        n_state     = r_state;
        n_dst_idx   = r_dst_idx;
        n_cost      = r_cost;
        n_last      = r_last;
        n_link      = r_link;
        n_link_hop  = r_link_hop;
        n_k         = r_k;
        n_changed   = r_changed;
        n_out_valid = r_out_valid;
        n_out_dest  = r_out_dest;
        n_out_cost  = r_out_cost;
        n_out_last  = r_out_last;
        wr.en       = 1'b0;
        wr.hop      = in_gate;
        wr_addr     = dst_x[IW-1:0];
        wr_cost     = in_cost;
        rd_addr     = r_dst_idx;

        // drop the held result once it is transferred
        if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            dvru_pkg::ST_IDLE: begin
                rd_addr = src_x[IW-1:0];
                if (accept) begin
                    n_dst_idx = dst_x[IW-1:0];
                    n_cost    = in_cost;
                    n_last    = s_axis_tlast;
                    n_k       = '0;
                    case (s_axis_tuser)
                        dvru_pkg::ACT_LOAD: begin
                            wr.en   = dst_ok;
                            wr_cost = in_cost[CB-1] ? '1 : in_cost;
                        end
                        dvru_pkg::ACT_NEIGH: begin
                            if (src_ok && dst_ok && !in_cost[CB-1]) begin
                                n_state = dvru_pkg::ST_RD_SRC;
                            end else if (s_axis_tlast && r_changed) begin
                                n_changed = 1'b0;
                                n_state   = dvru_pkg::ST_EMIT_RD;
                            end
                        end
                        dvru_pkg::ACT_ANNOUNCE: begin
                            n_state = dvru_pkg::ST_EMIT_RD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            dvru_pkg::ST_RD_SRC: begin
                n_link     = rd_cost;
                n_link_hop = rd_hop;
                rd_addr    = r_dst_idx;
                n_state    = dvru_pkg::ST_RD_DST;
            end
            dvru_pkg::ST_RD_DST: begin
                wr_addr = r_dst_idx;
                wr_cost = cand;
                wr.hop  = r_link_hop;
                // skip when nothing is reachable through the neighbour
                if (!r_link[CB-1] && better) begin
                    wr.en     = 1'b1;
                    n_changed = 1'b1;
                end
                if (r_last && n_changed) begin
                    n_changed = 1'b0;
                    n_state   = dvru_pkg::ST_EMIT_RD;
                end else begin
                    n_state   = dvru_pkg::ST_IDLE;
                end
            end
            dvru_pkg::ST_EMIT_RD: begin
                rd_addr = r_k;
                n_state = dvru_pkg::ST_EMIT_WR;
            end
            dvru_pkg::ST_EMIT_WR: begin
                rd_addr = r_k;
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_dest  = k_x[2:0];
                    n_out_cost  = rd_cost;
                    n_out_last  = (k_x == XW'(NODES - 1));
                    if (k_x == XW'(NODES - 1)) begin
                        n_state = dvru_pkg::ST_IDLE;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = dvru_pkg::ST_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = dvru_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dvru_pkg::ST_IDLE;
            r_changed   <= 1'b0;
            r_out_valid <= 1'b0;
            r_k         <= '0;
        end else begin
            r_state     <= n_state;
            r_changed   <= n_changed;
            r_out_valid <= n_out_valid;
            r_k         <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dst_idx  <= n_dst_idx;
        r_cost     <= n_cost;
        r_last     <= n_last;
        r_link     <= n_link;
        r_link_hop <= n_link_hop;
        r_out_dest <= n_out_dest;
        r_out_cost <= n_out_cost;
        r_out_last <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'({r_out_cost, r_out_dest});
    assign m_axis_tlast  = r_out_last;

endmodule

@@ tb/sv/tb_distance_vector_route_update_top.sv @@
module tb_distance_vector_route_update_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES     = 8;
    localparam int COST_BITS = 16;
    localparam int IN_W      = 32;
    localparam int OUT_W     = 24;
    localparam int MAX_COST  = 32767;
    localparam int ITEM_GOAL = 210;
    localparam int HOLD_LEN  = 300;
    localparam int DRAIN_LEN = 40;
    localparam int LIMIT     = 200000;

    // the one action code the package leaves unnamed; the block ignores it
    localparam logic [1:0] ACT_SPARE = 2'd3;

    typedef struct packed {
        logic [2:0]  dest;
        logic [15:0] cost;
        logic        last;
    } t_vec_entry;

    // Shadow routing table and the queue of vector entries it predicts.
    class route_table_model;
        logic signed [15:0] cost_tbl[NODES];
        logic [4:0]         hop_tbl[NODES];
        bit                 dirty;
        t_vec_entry         exp_vec[$];
        int                 errors;
        int                 n_results;

        function new();
            for (int i = 0; i < NODES; i++) begin
                cost_tbl[i] = -16'sd1;
                hop_tbl[i]  = 5'h1f;
            end
            dirty     = 1'b0;
            errors    = 0;
            n_results = 0;
        endfunction

        task report(input string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        function void push_vector();
            t_vec_entry e;
            for (int k = 0; k < NODES; k++) begin
                e.dest = k[2:0];
                e.cost = cost_tbl[k];
                e.last = (k == NODES - 1);
                exp_vec.push_back(e);
            end
        endfunction

        function void note_item(input logic [1:0] act, input logic [2:0] src,
                                input logic [2:0] dst, input logic signed [15:0] cost,
                                input logic signed [4:0] gate, input logic last);
            int link, cand, cur;
            case (act)
                dvru_pkg::ACT_LOAD: begin
                    cost_tbl[dst] = (cost < 0) ? -16'sd1 : cost;
                    hop_tbl[dst]  = gate;
                end
                dvru_pkg::ACT_ANNOUNCE: push_vector();
                dvru_pkg::ACT_NEIGH: begin
                    link = cost_tbl[src];
                    cur  = cost_tbl[dst];
                    // skip unreachable adverts and neighbours we cannot reach
                    if (cost >= 0 && link >= 0) begin
                        cand = int'(cost) + link;
                        if (cand > MAX_COST)
                            cand = MAX_COST;
                        if (cur < 0 || cur > cand) begin
                            cost_tbl[dst] = cand[15:0];
                            hop_tbl[dst]  = hop_tbl[src];
                            dirty         = 1'b1;
                        end
                    end
                    if (last && dirty) begin
                        dirty = 1'b0;
                        push_vector();
                    end
                end
                default: ;
            endcase
        endfunction

        task check_entry(input logic [OUT_W-1:0] tdata, input logic tlast);
            t_vec_entry e;
            n_results++;
            if (exp_vec.size() == 0) begin
                report($sformatf("unexpected result dest=%0d cost=%0h last=%0b",
                                 tdata[2:0], tdata[18:3], tlast));
            end else begin
                e = exp_vec.pop_front();
                if (tdata[2:0] !== e.dest)
                    report($sformatf("dest_out got %0d want %0d", tdata[2:0], e.dest));
                if (tdata[18:3] !== e.cost)
                    report($sformatf("cost_out dest %0d got %0h want %0h",
                                     e.dest, tdata[18:3], e.cost));
                if (tlast !== e.last)
                    report($sformatf("last_out dest %0d got %0b want %0b",
                                     e.dest, tlast, e.last));
            end
        endtask
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [IN_W-1:0]            s_axis_tdata = '0;  // source, dest, cost, gate
    logic [dvru_pkg::ACT_W-1:0] s_axis_tuser = '0;  // action
    logic                       s_axis_tlast = 1'b0; // last
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [OUT_W-1:0]           m_axis_tdata;       // dest_out, cost_out
    logic                       m_axis_tlast;       // last_out

    route_table_model  routes = new();
    int                n_sent = 0;
    int                n_cycles = 0;
    int                hold_cycles = 0;
    bit                no_idle = 1'b0;

    distance_vector_route_update_top #(
        .NODES     (NODES),
        .COST_BITS (COST_BITS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        forever begin
            @(posedge i_clk);
            n_cycles++;
            if (n_cycles >= LIMIT) begin
                $display("timeout after %0d cycles", n_cycles);
                $display("distance_vector_route_update_top regression: fail");
                $finish;
            end
        end
    end

    // receiver: random back-pressure, plus a long hold-off when requested
    initial begin
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                hold_cycles--;
            end else if (no_idle) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= 32);
            end
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            routes.check_entry(m_axis_tdata, m_axis_tlast);
    end

    function automatic logic signed [15:0] rand_cost();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return -16'sd1;
        if (r < 14)
            return 16'(MAX_COST);
        if (r < 20)
            return 16'($urandom_range(MAX_COST));
        return 16'($urandom_range(60));
    endfunction

    function automatic logic signed [4:0] rand_gate();
        int v;
        v = $urandom_range(16);
        return (v == 16) ? -5'sd1 : 5'(v);
    endfunction

    task automatic send_item(input logic [1:0] act, input logic [2:0] src,
                             input logic [2:0] dst, input logic signed [15:0] cost,
                             input logic signed [4:0] gate, input logic last);
        if (!no_idle) begin
            while ($urandom_range(99) < 32) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {5'd0, gate, cost, dst, src};
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        routes.note_item(act, src, dst, cost, gate, last);
        n_sent++;
    endtask

    task automatic send_vector(input logic [2:0] src);
        logic [2:0] base;
        int         len;
        base = 3'($urandom_range(7));
        len  = ($urandom_range(3) == 0) ? $urandom_range(1, NODES) : NODES;
        for (int k = 0; k < len; k++)
            send_item(dvru_pkg::ACT_NEIGH, src, base + 3'(k), rand_cost(), rand_gate(),
                      k == len - 1);
    endtask

    initial begin
        int  pick;
        bit  pressed;
        pressed = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, loads, relaxation corners, announce
        send_item(dvru_pkg::ACT_ANNOUNCE, 3'd0, 3'd0, 16'sd0, 5'sd0, 1'b0);
        send_item(dvru_pkg::ACT_NEIGH, 3'd4, 3'd5, 16'sd3, 5'sd0, 1'b1);
        send_item(dvru_pkg::ACT_LOAD, 3'd7, 3'd0, 16'sd0, 5'sd0, 1'b0);
        send_item(dvru_pkg::ACT_LOAD, 3'd0, 3'd1, 16'sd5, 5'sd1, 1'b1);
        send_item(dvru_pkg::ACT_LOAD, 3'd0, 3'd2, -16'sd1, -5'sd1, 1'b0);
        send_item(dvru_pkg::ACT_LOAD, 3'd0, 3'd3, 16'sd32767, 5'sd15, 1'b0);
        send_item(dvru_pkg::ACT_NEIGH, 3'd1, 3'd4, 16'sd10, 5'sd0, 1'b0);
        send_item(dvru_pkg::ACT_NEIGH, 3'd1, 3'd5, -16'sd1, 5'sd3, 1'b0);
        send_item(dvru_pkg::ACT_NEIGH, 3'd2, 3'd6, 16'sd3, 5'sd0, 1'b0);
        send_item(dvru_pkg::ACT_NEIGH, 3'd3, 3'd7, 16'sd32767, -5'sd1, 1'b0);
        send_item(dvru_pkg::ACT_NEIGH, 3'd1, 3'd4, 16'sd20, 5'sd0, 1'b1);
        send_item(dvru_pkg::ACT_NEIGH, 3'd1, 3'd4, 16'sd1, 5'sd0, 1'b1);
        send_item(dvru_pkg::ACT_NEIGH, 3'd0, 3'd0, 16'sd0, 5'sd0, 1'b1);
        send_item(ACT_SPARE, 3'd7, 3'd7, 16'sd32767, 5'sd15, 1'b1);
        send_item(dvru_pkg::ACT_LOAD, 3'd0, 3'd7, 16'sd100, 5'sd7, 1'b0);
        send_item(dvru_pkg::ACT_NEIGH, 3'd7, 3'd7, 16'sd0, 5'sd0, 1'b1);
        send_item(dvru_pkg::ACT_NEIGH, 3'd3, 3'd3, 16'sd32767, 5'sd0, 1'b1);
        send_item(dvru_pkg::ACT_LOAD, 3'd0, 3'd5, 16'sd40, -5'sd1, 1'b0);
        send_item(dvru_pkg::ACT_NEIGH, 3'd5, 3'd6, 16'sd2, 5'sd0, 1'b0);
        send_item(dvru_pkg::ACT_NEIGH, 3'd5, 3'd2, 16'sd32767, 5'sd0, 1'b1);
        send_item(dvru_pkg::ACT_ANNOUNCE, 3'd7, 3'd7, -16'sd1, -5'sd1, 1'b1);

        // random: mostly whole neighbour vectors, with loads, announces and noise
        while (n_sent < ITEM_GOAL) begin
            no_idle = (n_sent >= 60 && n_sent < 110);
            if (!pressed && n_sent >= 130) begin
                // stall the receiver so emitted vectors back up into the input
                pressed     = 1'b1;
                hold_cycles = HOLD_LEN;
                repeat (3) send_item(dvru_pkg::ACT_ANNOUNCE, 3'd0, 3'd0, 16'sd0, 5'sd0, 1'b0);
                send_vector(3'($urandom_range(7)));
            end
            pick = $urandom_range(99);
            if (pick < 58) begin
                send_vector(3'($urandom_range(7)));
            end else if (pick < 75) begin
                repeat ($urandom_range(1, 4))
                    send_item(dvru_pkg::ACT_LOAD, 3'($urandom_range(7)),
                              3'($urandom_range(7)), rand_cost(), rand_gate(),
                              1'($urandom_range(1)));
            end else if (pick < 85) begin
                send_item(dvru_pkg::ACT_ANNOUNCE, 3'($urandom_range(7)),
                          3'($urandom_range(7)), rand_cost(), rand_gate(),
                          1'($urandom_range(1)));
            end else begin
                send_item(2'($urandom_range(3)), 3'($urandom_range(7)),
                          3'($urandom_range(7)), rand_cost(), rand_gate(),
                          1'($urandom_range(1)));
            end
        end
        no_idle = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (routes.exp_vec.size() != 0) @(posedge i_clk);
        repeat (DRAIN_LEN) @(posedge i_clk);

        $display("covered %0d input transfers (loads, neighbour entries, announces, spare code)",
                 n_sent);
        $display("checked %0d result transfers, %0d full vectors, with one long receiver stall",
                 routes.n_results, routes.n_results / NODES);
        if (routes.errors == 0 && routes.exp_vec.size() == 0) begin
            $display("distance_vector_route_update_top regression: pass");
        end else begin
            $display("distance_vector_route_update_top regression: fail");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/dvru_pkg.sv
sv/dvru_table.sv
sv/distance_vector_route_update_top.sv
tb/sv/tb_distance_vector_route_update_top.sv
